// ===== hdl/ordered_value_list_table_unit_defines.svh =====
// assertion macros used by the checker file
`ifndef ORDERED_VALUE_LIST_TABLE_UNIT_DEFINES_SVH
`define ORDERED_VALUE_LIST_TABLE_UNIT_DEFINES_SVH

// clocked property, muted while reset is low
`define OVLT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ovlt check failed");

// clocked property, also checked during reset
`define OVLT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ovlt reset check failed");

`endif

// ===== hdl/ovlt_pkg.sv =====
`default_nettype none

package ovlt_pkg;

    // list geometry and field widths
    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 2;
    localparam int OUT_W     = 5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EXE
    } t_state;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic                     cmp_en;
        logic                     ins_en;
        logic                     rem_en;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== hdl/ovlt_cell.sv =====
`default_nettype none

module ovlt_cell (
    input  wire logic                             i_clk,
    input  wire ovlt_pkg::t_cell_ctl              i_ctl,
    input  wire logic                             i_occupied,
    input  wire logic                             i_is_tail,
    input  wire logic                             i_hit_in,
    input  wire logic signed [ovlt_pkg::DATA_W-1:0] i_next_data,
    output logic                                  o_hit_out,
    output logic                                  o_first,
    output logic signed [ovlt_pkg::DATA_W-1:0]    o_data
);

    logic signed [ovlt_pkg::DATA_W-1:0] r_data;
    logic                               r_match;
    logic                               w_shift;

    // hit chain toward the tail, first match is the cell that starts it
    assign o_hit_out = i_hit_in | r_match;
    assign o_first   = r_match & ~i_hit_in;
    assign o_data    = r_data;

    // on remove, this cell and every later one take the neighbor's value
    assign w_shift = i_ctl.rem_en & (i_hit_in | r_match);

    // compare against the broadcast value
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_match <= i_occupied && (r_data == i_ctl.value);
        end
    end

    // tail write or shift toward the head
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins_en && i_is_tail) begin
            r_data <= i_ctl.value;
        end else if (w_shift) begin
            r_data <= i_next_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ordered_value_list_table_unit.sv =====
`default_nettype none

// channel  | handshake          | payload
// ---------+--------------------+------------------------------------------
// input    | i_valid / o_ready  | i_cmd, i_value
// result   | o_valid / i_ready  | o_position, o_ok, o_full_res, o_count
//
// the compare state compares the value in every cell; the execute state
// resolves the first match along the cell chain, writes the tail or
// shifts the cells behind the match, and takes the next beat once the
// result is free. a stalled result holds in the output register; the
// sequencer waits. reset clears count and handshake, not the entries.

module ordered_value_list_table_unit #(
    parameter int DEPTH = ovlt_pkg::DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [ovlt_pkg::CMD_W-1:0]        i_cmd,
    input  wire logic signed [ovlt_pkg::DATA_W-1:0] i_value,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [ovlt_pkg::OUT_W-1:0]             o_position,
    output logic                                   o_ok,
    output logic                                   o_full_res,
    output logic [ovlt_pkg::OUT_W-1:0]             o_count
);

    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int OUTW = ovlt_pkg::OUT_W;

    ovlt_pkg::t_state    r_state, n_state;
    ovlt_pkg::t_cell_ctl w_ctl;

    logic [ovlt_pkg::CMD_W-1:0]         r_cmd;
    logic signed [ovlt_pkg::DATA_W-1:0] r_value;
    logic [CNTW-1:0]                    r_count, n_count;

    logic r_out_valid;
    logic [OUTW-1:0] r_position, r_out_count;
    logic r_ok, r_full_res;

    logic w_out_free, w_accept, w_exe_fire, w_cmp_en;
    logic w_full, w_any_hit;
    logic n_ok, n_full_res, w_use_pos;
    logic [CNTW-1:0] w_pos;
    logic [CNTW+OUTW-1:0] w_pos_wide, w_cnt_wide;

    logic [DEPTH:0]   w_hit;
    logic [DEPTH-1:0] w_first;
    logic signed [ovlt_pkg::DATA_W-1:0] w_data [DEPTH];

    // handshake
    assign w_out_free = !r_out_valid || i_ready;
    assign w_accept   = i_valid && o_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ovlt_pkg::ST_IDLE: if (w_accept) n_state = ovlt_pkg::ST_CMP;
            ovlt_pkg::ST_CMP:  n_state = ovlt_pkg::ST_EXE;
            ovlt_pkg::ST_EXE: begin
                if (w_out_free) begin
                    n_state = w_accept ? ovlt_pkg::ST_CMP : ovlt_pkg::ST_IDLE;
                end
            end
            default: n_state = ovlt_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_ready    = 1'b0;
        w_cmp_en   = 1'b0;
        w_exe_fire = 1'b0;
        unique case (r_state)
            ovlt_pkg::ST_IDLE: o_ready = 1'b1;
            ovlt_pkg::ST_CMP:  w_cmp_en = 1'b1;
            ovlt_pkg::ST_EXE: begin
                w_exe_fire = w_out_free;
                o_ready    = w_out_free;
            end
            default: o_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ovlt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // capture the accepted beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_cmd;
            r_value <= i_value;
        end
    end

    assign w_full = (r_count == CNTW'(DEPTH));

    // broadcast to the cells
    always_comb begin
        w_ctl.cmp_en = w_cmp_en;
        w_ctl.ins_en = w_exe_fire && (r_cmd == ovlt_pkg::CMD_INSERT) && !w_full;
        w_ctl.rem_en = w_exe_fire && (r_cmd == ovlt_pkg::CMD_REMOVE);
        w_ctl.value  = r_value;
    end

    // cell chain, head at index zero
    assign w_hit[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [ovlt_pkg::DATA_W-1:0] w_next;
        if (g < DEPTH - 1) begin : g_mid
            assign w_next = w_data[g+1];
        end else begin : g_last
            assign w_next = w_data[g];
        end
        ovlt_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occupied  (CNTW'(g) < r_count),
            .i_is_tail   (CNTW'(g) == r_count),
            .i_hit_in    (w_hit[g]),
            .i_next_data (w_next),
            .o_hit_out   (w_hit[g+1]),
            .o_first     (w_first[g]),
            .o_data      (w_data[g])
        );
    end

    assign w_any_hit = w_hit[DEPTH];

    // one-hot first match to 1-based position
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_first[i]) begin
                w_pos = w_pos | CNTW'(i + 1);
            end
        end
    end

    // result and count update
    always_comb begin
        n_count    = r_count;
        n_ok       = 1'b0;
        n_full_res = 1'b0;
        w_use_pos  = 1'b1;
        unique case (r_cmd)
            ovlt_pkg::CMD_INSERT: begin
                n_ok       = !w_full;
                n_full_res = w_full;
                if (!w_full) n_count = r_count + CNTW'(1);
            end
            ovlt_pkg::CMD_LOOKUP: n_ok = w_any_hit;
            ovlt_pkg::CMD_REMOVE: begin
                n_ok = w_any_hit;
                if (w_any_hit) n_count = r_count - CNTW'(1);
            end
            default: w_use_pos = 1'b0;
        endcase
    end

    assign w_pos_wide = {OUTW'(0), (w_use_pos ? w_pos : CNTW'(0))};
    assign w_cnt_wide = {OUTW'(0), n_count};

    // count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_exe_fire) begin
            r_count <= n_count;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_exe_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exe_fire) begin
            r_position  <= w_pos_wide[OUTW-1:0];
            r_ok        <= n_ok;
            r_full_res  <= n_full_res;
            r_out_count <= w_cnt_wide[OUTW-1:0];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_position = r_position;
    assign o_ok       = r_ok;
    assign o_full_res = r_full_res;
    assign o_count    = r_out_count;

endmodule

`default_nettype wire

// ===== hdl/ovlt_checker.sv =====
`default_nettype none

`include "ordered_value_list_table_unit_defines.svh"

module ovlt_checker #(
    parameter int DEPTH = ovlt_pkg::DEPTH_DEF
) (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_valid,
    input wire logic                              o_ready,
    input wire logic                              o_valid,
    input wire logic                              i_ready,
    input wire logic [ovlt_pkg::OUT_W-1:0]        o_position,
    input wire logic                              o_ok,
    input wire logic                              o_full_res,
    input wire logic [ovlt_pkg::OUT_W-1:0]        o_count
);

    // a stalled result beat holds
    `OVLT_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable({o_position, o_ok, o_full_res, o_count}))

    // a dropped insert never reports success
    `OVLT_ASSERT(a_full_not_ok, i_clk, i_rst_n, o_valid |-> !(o_full_res && o_ok))

    // a dropped insert only happens at full depth
    `OVLT_ASSERT(a_full_count, i_clk, i_rst_n, o_valid && o_full_res |-> o_count == ovlt_pkg::OUT_W'(DEPTH))

    // an accepted beat is followed by the compare cycle
    `OVLT_ASSERT(a_one_at_a_time, i_clk, i_rst_n, i_valid && o_ready |=> !o_ready)

    // no result right after reset
    `OVLT_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind ordered_value_list_table_unit ovlt_checker #(.DEPTH(DEPTH)) u_ovlt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_position (o_position),
    .o_ok       (o_ok),
    .o_full_res (o_full_res),
    .o_count    (o_count)
);

`default_nettype wire
